[sv/sbalu_pkg.sv]
`default_nettype none
package sbalu_pkg;

  localparam logic [4:0] OP_SET = 5'h01;
  localparam logic [4:0] OP_ADD = 5'h02;
  localparam logic [4:0] OP_SUB = 5'h03;
  localparam logic [4:0] OP_MUL = 5'h04;
  localparam logic [4:0] OP_MLI = 5'h05;
  localparam logic [4:0] OP_DIV = 5'h06;
  localparam logic [4:0] OP_DVI = 5'h07;
  localparam logic [4:0] OP_MOD = 5'h08;
  localparam logic [4:0] OP_MDI = 5'h09;
  localparam logic [4:0] OP_AND = 5'h0A;
  localparam logic [4:0] OP_BOR = 5'h0B;
  localparam logic [4:0] OP_XOR = 5'h0C;
  localparam logic [4:0] OP_SHR = 5'h0D;
  localparam logic [4:0] OP_ASR = 5'h0E;
  localparam logic [4:0] OP_SHL = 5'h0F;
  localparam logic [4:0] OP_IFB = 5'h10;
  localparam logic [4:0] OP_IFC = 5'h11;
  localparam logic [4:0] OP_IFE = 5'h12;
  localparam logic [4:0] OP_IFN = 5'h13;
  localparam logic [4:0] OP_IFG = 5'h14;
  localparam logic [4:0] OP_IFA = 5'h15;
  localparam logic [4:0] OP_IFL = 5'h16;
  localparam logic [4:0] OP_IFU = 5'h17;
  localparam logic [4:0] OP_ADX = 5'h1A;
  localparam logic [4:0] OP_SBX = 5'h1B;
  localparam logic [4:0] OP_STI = 5'h1E;
  localparam logic [4:0] OP_STD = 5'h1F;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  localparam int DivBits = 32;
  localparam int RemCapture = 15;

  typedef struct packed {
    logic [4:0]  op;
    logic        a_zero;
    logic [15:0] nb;
    logic [15:0] nex;
    logic        run;
    logic [1:0]  step;
    logic [1:0]  cyc;
    logic        neg_q;
    logic        neg_r;
    logic [16:0] rem;
    logic [31:0] dq;
    logic [15:0] d;
    logic [15:0] r16;
  } item_t;

  function automatic logic [1:0] base_cycles(input logic [4:0] op);
    logic [1:0] c;
    c = 2'd0;
    case (op)
      OP_SET, OP_AND, OP_BOR, OP_XOR, OP_SHR, OP_ASR, OP_SHL: c = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_MLI: c = 2'd2;
      OP_IFB, OP_IFC, OP_IFE, OP_IFN, OP_IFG, OP_IFA, OP_IFL, OP_IFU: c = 2'd2;
      OP_STI, OP_STD: c = 2'd2;
      OP_DIV, OP_DVI, OP_MOD, OP_MDI, OP_ADX, OP_SBX: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/sbalu_div_stage.sv]
`default_nettype none
module sbalu_div_stage import sbalu_pkg::*; #(
  parameter int K     = 2,
  parameter int FIRST = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire item_t in_item_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output item_t      out_item_o,
  input  wire logic  out_ready_i
);

  logic  valid_q;
  item_t item_q, item_d;

  always_comb begin
    logic [16:0] sh;
    logic        ge;
    item_d = in_item_i;
    for (int i = 0; i < K; i++) begin
      sh = {item_d.rem[15:0], item_d.dq[31]};
      ge = (sh >= {1'b0, item_d.d});
      item_d.rem = ge ? (sh - {1'b0, item_d.d}) : sh;
      item_d.dq  = {item_d.dq[30:0], ge};
      if (FIRST + i == RemCapture) begin
        item_d.r16 = item_d.rem[15:0];
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

[sv/sixteen_bit_alu_with_overflow_word_core.sv]
// Sixteen-bit ALU execute stage with overflow word. Fully pipelined: one
// instruction per cycle while out_ready_i is high; every opcode passes the front
// register, the restoring divider stages (STEPS_PER_STAGE quotient bits per
// stage) and the output register; STEPS_PER_STAGE must divide 32.
`default_nettype none
module sixteen_bit_alu_with_overflow_word_core import sbalu_pkg::*; #(
  parameter int STEPS_PER_STAGE = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [4:0]  mode_i,
  input  wire logic [15:0] operand_a_i,
  input  wire logic [15:0] operand_b_i,
  input  wire logic [15:0] overflow_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      result_b_o,
  output logic [15:0]      overflow_out_o,
  output logic             run_next_o,
  output logic [1:0]       index_step_o,
  output logic [1:0]       base_cycles_o
);

  localparam int NStages = DivBits / STEPS_PER_STAGE;

  logic  v   [0:NStages];
  item_t it  [0:NStages];
  logic  rdy [0:NStages+1];

  // front end
  item_t front;
  always_comb begin
    logic [15:0] a, b, ex, ma, mb;
    logic [16:0] s17;
    logic [17:0] s18;
    logic signed [18:0] t19;
    logic [31:0] pu, r32;
    logic signed [31:0] ps, rs;
    logic [4:0] sh;
    logic sgn;
    a  = operand_a_i;
    b  = operand_b_i;
    ex = overflow_in_i;
    s17 = {1'b0, a} + {1'b0, b};
    s18 = {2'b0, a} + {2'b0, b} + {2'b0, ex};
    t19 = $signed({3'b0, b}) - $signed({3'b0, a}) + $signed({3'b0, ex});
    pu  = {16'h0, a} * {16'h0, b};
    ps  = $signed({{16{a[15]}}, a}) * $signed({{16{b[15]}}, b});
    sh  = (a > 16'd31) ? 5'd31 : a[4:0];
    rs  = $signed({b, 16'h0}) >>> sh;
    r32 = 32'h0;
    sgn = (mode_i == OP_DVI) || (mode_i == OP_MDI);
    ma  = (sgn && a[15]) ? (~a + 16'd1) : a;
    mb  = (sgn && b[15]) ? (~b + 16'd1) : b;

    front        = '0;
    front.op     = mode_i;
    front.a_zero = (a == 16'h0);
    front.nb     = b;
    front.nex    = ex;
    front.run    = 1'b1;
    front.step   = STEP_NONE;
    front.cyc    = base_cycles(mode_i);
    front.neg_q  = sgn && (a[15] ^ b[15]);
    front.neg_r  = sgn && b[15];
    front.rem    = '0;
    front.dq     = {mb, 16'h0};
    front.d      = ma;
    front.r16    = '0;

    case (mode_i)
      OP_SET: front.nb = a;
      OP_ADD: begin
        front.nb  = s17[15:0];
        front.nex = {15'h0, s17[16]};
      end
      OP_SUB: begin
        front.nb  = b - a;
        front.nex = (b < a) ? 16'hFFFF : 16'h0;
      end
      OP_MUL: begin
        front.nb  = pu[15:0];
        front.nex = pu[31:16];
      end
      OP_MLI: begin
        front.nb  = ps[15:0];
        front.nex = ps[31:16];
      end
      OP_AND: front.nb = b & a;
      OP_BOR: front.nb = b | a;
      OP_XOR: front.nb = b ^ a;
      OP_SHR: begin
        if (a >= 16'd32) begin
          front.nb  = 16'h0;
          front.nex = 16'h0;
        end else begin
          r32 = {b, 16'h0} >> a[4:0];
          front.nb  = r32[31:16];
          front.nex = r32[15:0];
        end
      end
      OP_ASR: begin
        front.nb  = rs[31:16];
        front.nex = rs[15:0];
      end
      OP_SHL: begin
        if (a >= 16'd32) begin
          front.nb  = 16'h0;
          front.nex = 16'h0;
        end else begin
          r32 = {16'h0, b} << a[4:0];
          front.nb  = r32[15:0];
          front.nex = r32[31:16];
        end
      end
      OP_IFB: front.run = ((b & a) != 16'h0);
      OP_IFC: front.run = ((b & a) == 16'h0);
      OP_IFE: front.run = (b == a);
      OP_IFN: front.run = (b != a);
      OP_IFG: front.run = (b > a);
      OP_IFA: front.run = ($signed(b) > $signed(a));
      OP_IFL: front.run = (b < a);
      OP_IFU: front.run = ($signed(b) < $signed(a));
      OP_ADX: begin
        front.nb  = s18[15:0];
        front.nex = (s18 >= 18'h10000) ? 16'h1 : 16'h0;
      end
      OP_SBX: begin
        front.nb  = t19[15:0];
        front.nex = t19[18] ? 16'hFFFF : 16'h0;
      end
      OP_STI: begin
        front.nb   = a;
        front.step = STEP_INC;
      end
      OP_STD: begin
        front.nb   = a;
        front.step = STEP_DEC;
      end
      default: ;
    endcase
  end

  logic  s0_valid_q;
  item_t s0_item_q;

  assign rdy[0]     = !s0_valid_q || rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (rdy[0]) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      s0_item_q <= front;
    end
  end

  assign v[0]  = s0_valid_q;
  assign it[0] = s0_item_q;

  for (genvar j = 1; j <= NStages; j++) begin : g_div
    sbalu_div_stage #(
      .K     (STEPS_PER_STAGE),
      .FIRST ((j - 1) * STEPS_PER_STAGE)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (v[j-1]),
      .in_item_i   (it[j-1]),
      .in_ready_o  (rdy[j]),
      .out_valid_o (v[j]),
      .out_item_o  (it[j]),
      .out_ready_i (rdy[j+1])
    );
  end

  // sign fix and divide-by-zero handling
  item_t       last;
  logic [15:0] fin_b_d, fin_ex_d;
  always_comb begin
    last     = it[NStages];
    fin_b_d  = last.nb;
    fin_ex_d = last.nex;
    case (last.op)
      OP_DIV, OP_DVI: begin
        if (last.a_zero) begin
          fin_b_d  = 16'h0;
          fin_ex_d = 16'h0;
        end else if (last.neg_q) begin
          fin_b_d  = ~last.dq[31:16] + 16'd1;
          fin_ex_d = ~last.dq[15:0] + 16'd1;
        end else begin
          fin_b_d  = last.dq[31:16];
          fin_ex_d = last.dq[15:0];
        end
      end
      OP_MOD, OP_MDI: begin
        if (last.a_zero) begin
          fin_b_d = 16'h0;
        end else begin
          fin_b_d = last.neg_r ? (~last.r16 + 16'd1) : last.r16;
        end
      end
      default: ;
    endcase
  end

  logic        out_valid_q;
  logic [15:0] out_b_q, out_ex_q;
  logic        out_run_q;
  logic [1:0]  out_step_q, out_cyc_q;

  assign rdy[NStages+1] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[NStages+1]) begin
      out_valid_q <= v[NStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NStages+1] && v[NStages]) begin
      out_b_q    <= fin_b_d;
      out_ex_q   <= fin_ex_d;
      out_run_q  <= last.run;
      out_step_q <= last.step;
      out_cyc_q  <= last.cyc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_b_o     = out_b_q;
  assign overflow_out_o = out_ex_q;
  assign run_next_o     = out_run_q;
  assign index_step_o   = out_step_q;
  assign base_cycles_o  = out_cyc_q;

endmodule
`default_nettype wire
